// ===== src/stc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the seconds-to-calendar converter
// Field widths, the micro-op and condition codes, the control word and the
// microcode program, plus the month-length lookup used by the datapath.
// ----------------------------------------------------------------------------
package stc_pkg;

	// Field widths of the two channels
	localparam int SECONDS_W = 32;
	localparam int YEAR_W    = 12;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int SECOND_W  = 6;

	// Internal widths
	localparam int DAYS_W    = 16;   // day count never exceeds 49710
	localparam int YLEN_W    = 9;
	localparam int PROD_W    = 2 * SECONDS_W;

	// Calendar constants
	localparam logic [YEAR_W-1:0] YEAR_BASE   = 12'd2000;
	localparam logic [YLEN_W-1:0] DAYS_LEAP   = 9'd366;
	localparam logic [YLEN_W-1:0] DAYS_COMMON = 9'd365;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd11;   // zero-based December
	localparam logic [1:0] MOD4_LAST          = 2'd3;
	localparam logic [6:0] MOD100_LAST        = 7'd99;
	localparam logic [8:0] MOD400_LAST        = 9'd399;

	// Reciprocal constants: x/60 = (x*M60) >> 37 and x/24 = (x*M24) >> 36,
	// exact for every 32-bit x
	localparam logic [SECONDS_W-1:0] MAGIC_DIV60 = 32'h8888_8889;
	localparam logic [SECONDS_W-1:0] MAGIC_DIV24 = 32'hAAAA_AAAB;
	localparam int SHIFT_DIV60 = 37;
	localparam int SHIFT_DIV24 = 36;
	localparam logic [SECONDS_W-1:0] DIV_60 = 32'd60;
	localparam logic [SECONDS_W-1:0] DIV_24 = 32'd24;

	// Micro-operations executed by the datapath
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL60,
		OP_MUL24,
		OP_SPLIT_SEC,
		OP_SPLIT_MIN,
		OP_SPLIT_HR,
		OP_YEAR_ADV,
		OP_MONTH_ADV,
		OP_EMIT
	} op_t;

	// Jump conditions tested by the sequencer
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_INPUT,
		COND_YEAR_DONE,
		COND_MONTH_DONE,
		COND_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	// Program addresses
	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_MUL_S  = 4'd1;
	localparam step_t STEP_SEC    = 4'd2;
	localparam step_t STEP_MUL_M  = 4'd3;
	localparam step_t STEP_MIN    = 4'd4;
	localparam step_t STEP_MUL_H  = 4'd5;
	localparam step_t STEP_HOUR   = 4'd6;
	localparam step_t STEP_YEAR   = 4'd7;
	localparam step_t STEP_MONTH  = 4'd8;
	localparam step_t STEP_EMIT   = 4'd9;

	// One control word: if cond holds, go to jmp and skip op;
	// otherwise execute op and go to nxt
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic idle;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic no_input;
		logic year_done;
		logic month_done;
		logic out_busy;
	} status_t;

	// Microcode program
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		case (pc)
			STEP_IDLE:  w = '{OP_LOAD,      COND_NO_INPUT,   STEP_IDLE,  STEP_MUL_S};
			STEP_MUL_S: w = '{OP_MUL60,     COND_NEVER,      STEP_IDLE,  STEP_SEC};
			STEP_SEC:   w = '{OP_SPLIT_SEC, COND_NEVER,      STEP_IDLE,  STEP_MUL_M};
			STEP_MUL_M: w = '{OP_MUL60,     COND_NEVER,      STEP_IDLE,  STEP_MIN};
			STEP_MIN:   w = '{OP_SPLIT_MIN, COND_NEVER,      STEP_IDLE,  STEP_MUL_H};
			STEP_MUL_H: w = '{OP_MUL24,     COND_NEVER,      STEP_IDLE,  STEP_HOUR};
			STEP_HOUR:  w = '{OP_SPLIT_HR,  COND_NEVER,      STEP_IDLE,  STEP_YEAR};
			STEP_YEAR:  w = '{OP_YEAR_ADV,  COND_YEAR_DONE,  STEP_MONTH, STEP_YEAR};
			STEP_MONTH: w = '{OP_MONTH_ADV, COND_MONTH_DONE, STEP_EMIT,  STEP_MONTH};
			STEP_EMIT:  w = '{OP_EMIT,      COND_OUT_BUSY,   STEP_EMIT,  STEP_IDLE};
			default:    w = '{OP_NOP,       COND_NEVER,      STEP_IDLE,  STEP_IDLE};
		endcase
		return w;
	endfunction

	// Days in a zero-based month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (mon)
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd3,
			4'd5,
			4'd8,
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== src/stc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_if: valid/ready channels of the seconds-to-calendar converter
// stc_in_if carries the elapsed seconds, stc_out_if the calendar fields.
// ----------------------------------------------------------------------------
interface stc_in_if;
	logic                           valid;
	logic                           ready;
	logic [stc_pkg::SECONDS_W-1:0] elapsed_seconds;

	modport source (output valid, output elapsed_seconds, input ready);
	modport sink   (input valid, input elapsed_seconds, output ready);
endinterface

interface stc_out_if;
	logic                          valid;
	logic                          ready;
	logic [stc_pkg::YEAR_W-1:0]   year;
	logic [stc_pkg::MONTH_W-1:0]  month;
	logic [stc_pkg::DAY_W-1:0]    day_of_month;
	logic [stc_pkg::HOUR_W-1:0]   hour;
	logic [stc_pkg::MINUTE_W-1:0] minute;
	logic [stc_pkg::SECOND_W-1:0] second;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, input ready);
	modport sink   (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

// ===== src/stc_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_sequencer: microcode step counter
// Fetches the control word at the current step, tests its jump condition
// and issues the micro-op to the datapath.
// ----------------------------------------------------------------------------
module stc_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stc_pkg::status_t status,
	output stc_pkg::ctrl_t        ctrl
);
	import stc_pkg::*;

	step_t  pc_q;
	ucode_t word;
	logic   taken;

	// Fetch and evaluate the jump condition
	always_comb begin
		word = ucode_rom(pc_q);
		case (word.cond)
			COND_NEVER:      taken = 1'b0;
			COND_NO_INPUT:   taken = status.no_input;
			COND_YEAR_DONE:  taken = status.year_done;
			COND_MONTH_DONE: taken = status.month_done;
			COND_OUT_BUSY:   taken = status.out_busy;
			default:         taken = 1'b0;
		endcase
	end

	// Drop the op on a taken jump
	assign ctrl.op   = taken ? OP_NOP : word.op;
	assign ctrl.idle = (pc_q == STEP_IDLE);

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= taken ? word.jmp : word.nxt;
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_EMIT)
		else $error("step counter left the program");

	a_year_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_YEAR && status.year_done) |=> pc_q == STEP_MONTH)
		else $error("year loop did not hand over to month loop");

	a_emit_return: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_EMIT |=> pc_q == STEP_IDLE)
		else $error("sequencer did not return to idle after emit");

endmodule
`default_nettype wire

// ===== src/stc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_datapath: registers and arithmetic of the converter
// One reciprocal multiplier splits off seconds, minutes and hours; a
// subtractor with leap-year counters walks years, then months. Holds the
// result register toward the output channel.
// ----------------------------------------------------------------------------
module stc_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire stc_pkg::ctrl_t   ctrl,
	output stc_pkg::status_t      status,
	stc_in_if.sink                timestamp,
	stc_out_if.source             calendar
);
	import stc_pkg::*;

	logic [SECONDS_W-1:0] val_q;
	logic [PROD_W-1:0]    prod_q;
	logic [PROD_W-1:0]    prod_d;
	logic [SECONDS_W-1:0] magic;
	logic [SECOND_W-1:0]  sec_q;
	logic [MINUTE_W-1:0]  min_q;
	logic [HOUR_W-1:0]    hr_q;
	logic [DAYS_W-1:0]    days_q;
	logic [YEAR_W-1:0]    year_q;
	logic [1:0]           mod4_q;
	logic [6:0]           mod100_q;
	logic [8:0]           mod400_q;
	logic [MONTH_W-1:0]   mon_q;
	logic                 out_valid_q;
	logic [YEAR_W-1:0]    out_year_q;
	logic [MONTH_W-1:0]   out_month_q;
	logic [DAY_W-1:0]     out_day_q;
	logic [HOUR_W-1:0]    out_hour_q;
	logic [MINUTE_W-1:0]  out_minute_q;
	logic [SECOND_W-1:0]  out_second_q;

	logic [SECONDS_W-SHIFT_DIV60-1+SECONDS_W:0] q60;
	logic [SECONDS_W-SHIFT_DIV24-1+SECONDS_W:0] q24;
	logic                 leap;
	logic [YLEN_W-1:0]    ylen;
	logic [DAY_W-1:0]     mlen;

	// Reciprocal multiply for the next division
	assign magic  = (ctrl.op == OP_MUL24) ? MAGIC_DIV24 : MAGIC_DIV60;
	assign prod_d = PROD_W'(val_q) * PROD_W'(magic);
	assign q60    = prod_q[PROD_W-1:SHIFT_DIV60];
	assign q24    = prod_q[PROD_W-1:SHIFT_DIV24];

	// Leap rule from the running year residues
	assign leap = (mod400_q == '0) || ((mod4_q == '0) && (mod100_q != '0));
	assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
	assign mlen = month_len(mon_q, leap);

	// Conditions for the sequencer
	assign status.no_input   = !timestamp.valid;
	assign status.year_done  = days_q < DAYS_W'(ylen);
	assign status.month_done = (mon_q == MONTH_DEC) || (days_q < DAYS_W'(mlen));
	assign status.out_busy   = out_valid_q && !calendar.ready;

	// Take a new item only at the idle step
	assign timestamp.ready = ctrl.idle;

	// Working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				val_q    <= timestamp.elapsed_seconds;
				year_q   <= YEAR_BASE;
				mod4_q   <= '0;
				mod100_q <= '0;
				mod400_q <= '0;
				mon_q    <= '0;
			end
			OP_MUL60, OP_MUL24: begin
				prod_q <= prod_d;
			end
			OP_SPLIT_SEC: begin
				sec_q <= SECOND_W'(val_q - SECONDS_W'(q60) * DIV_60);
				val_q <= SECONDS_W'(q60);
			end
			OP_SPLIT_MIN: begin
				min_q <= MINUTE_W'(val_q - SECONDS_W'(q60) * DIV_60);
				val_q <= SECONDS_W'(q60);
			end
			OP_SPLIT_HR: begin
				hr_q   <= HOUR_W'(val_q - SECONDS_W'(q24) * DIV_24);
				days_q <= DAYS_W'(q24);
			end
			OP_YEAR_ADV: begin
				days_q   <= days_q - DAYS_W'(ylen);
				year_q   <= year_q + 1'b1;
				mod4_q   <= mod4_q + 1'b1;
				mod100_q <= (mod100_q == MOD100_LAST) ? '0 : mod100_q + 1'b1;
				mod400_q <= (mod400_q == MOD400_LAST) ? '0 : mod400_q + 1'b1;
			end
			OP_MONTH_ADV: begin
				days_q <= days_q - DAYS_W'(mlen);
				mon_q  <= mon_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result register: load on emit, release on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (calendar.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT) begin
			out_year_q   <= year_q;
			out_month_q  <= mon_q + 1'b1;
			out_day_q    <= days_q[DAY_W-1:0] + 1'b1;
			out_hour_q   <= hr_q;
			out_minute_q <= min_q;
			out_second_q <= sec_q;
		end
	end

	assign calendar.valid        = out_valid_q;
	assign calendar.year         = out_year_q;
	assign calendar.month        = out_month_q;
	assign calendar.day_of_month = out_day_q;
	assign calendar.hour         = out_hour_q;
	assign calendar.minute       = out_minute_q;
	assign calendar.second       = out_second_q;

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_EMIT |=> calendar.valid)
		else $error("emitted item not presented");

	a_load_base: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_LOAD |=> year_q == YEAR_BASE && mon_q == '0)
		else $error("year walk not started at base year");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_MONTH_ADV |-> mon_q < MONTH_DEC)
		else $error("month advanced past December");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_EMIT |-> hr_q < HOUR_W'(24) && min_q < MINUTE_W'(60)
			&& sec_q < SECOND_W'(60) && days_q < DAYS_W'(31))
		else $error("time of day or day out of range at emit");

endmodule
`default_nettype wire

// ===== src/seconds_to_calendar_time.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_to_calendar_time: seconds since 2000-01-01 to Gregorian date/time
// Top level: microcode sequencer driving the conversion datapath.
// ----------------------------------------------------------------------------
// Converts one 32-bit count of seconds since 2000-01-01 00:00:00 into year,
// month, day of month, hour, minute and second (no time zone, full Gregorian
// leap rule). The block works on one item at a time. An item passes the load
// step, the multiply and split steps for seconds, minutes and hours, a year
// walk of one year per cycle over the Y years past 2000 (0..136), a month
// walk over the zero-based month M (0..11), as the largest input falls in
// February 2136, and the emit step, held while an earlier result is unread.
// The next item is accepted once the result is loaded into the output
// register, even while that result still waits on the output channel.
// ----------------------------------------------------------------------------
module seconds_to_calendar_time (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stc_in_if.sink     timestamp,
	stc_out_if.source  calendar
);
	import stc_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	// Step counter and microcode program
	stc_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Arithmetic and result register
	stc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.timestamp (timestamp),
		.calendar  (calendar)
	);

endmodule
`default_nettype wire
